// File: rtl/sobel_inverted_edge_magnitude_core_assert.svh
// Assertion helpers shared by the queue and back-end modules.
// Each macro expects clk and arst_n in scope.
`ifndef SOBEL_INVERTED_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_INVERTED_EDGE_MAGNITUDE_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define SIEM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define SIEM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/siem_pkg.sv
`default_nettype none

package siem_pkg;

	// Pixel and result widths
	localparam int PIX_W   = 8;
	localparam int EDGE_W  = 8;
	localparam int PIX_MAX = 255;

	// Gradient magnitude fits 10 bits (at most 4 * 255)
	localparam int GRAD_W   = 10;
	localparam int SQ_W     = 2 * GRAD_W;
	// Energy padded to an even width, one root bit per digit pair
	localparam int ROOT_W   = 11;
	localparam int ENERGY_W = 2 * ROOT_W;
	localparam int REM_W    = ROOT_W + 1;
	localparam int STEP_W   = $clog2(ROOT_W);

	// Configuration registers
	localparam int CFG_W       = 12;
	localparam int MIN_DIM     = 3;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} siem_reg_t;

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [GRAD_W-1:0] gx_abs;
		logic [GRAD_W-1:0] gy_abs;
		logic              last;
	} siem_job_t;

endpackage

`default_nettype wire

// File: rtl/siem_pixel_if.sv
`default_nettype none

interface siem_pixel_if;
	import siem_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] gray_pixel;

	modport source (output valid, output gray_pixel, input ready);
	modport sink (input valid, input gray_pixel, output ready);

endinterface

`default_nettype wire

// File: rtl/siem_result_if.sv
`default_nettype none

interface siem_result_if;
	import siem_pkg::*;

	logic              valid;
	logic              ready;
	logic [EDGE_W-1:0] edge_value;
	logic              last_of_frame;

	modport source (output valid, output edge_value, output last_of_frame, input ready);
	modport sink (input valid, input edge_value, input last_of_frame, output ready);

endinterface

`default_nettype wire

// File: rtl/siem_fifo.sv
`default_nettype none
`include "sobel_inverted_edge_magnitude_core_assert.svh"

module siem_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  siem_pkg::siem_job_t              push_job,
	input  logic                             pop,
	output siem_pkg::siem_job_t              head_job,
	output logic                             head_valid,
	output logic [siem_pkg::LVL_W-1:0]       level
);
	import siem_pkg::*;

	siem_job_t        job_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) level_q <= level_q + 1'b1;
			else if (pop && !push) level_q <= level_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) job_q[wr_ptr_q] <= push_job;
	end

	assign head_job   = job_q[rd_ptr_q];
	assign head_valid = (level_q != '0);
	assign level      = level_q;

	`SIEM_ASSERT_IMP(a_no_overflow, push, (level_q < LVL_W'(FIFO_DEPTH)) || pop, "queue overflow")
	`SIEM_ASSERT_IMP(a_no_underflow, pop, level_q != '0, "queue underflow")
	`SIEM_ASSERT_NXT(a_level_up, push && !pop, level_q == $past(level_q) + 1'b1, "level lost a push")

endmodule

`default_nettype wire

// File: rtl/siem_front.sv
`default_nettype none

module siem_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [siem_pkg::CFG_W-1:0]       frame_width,
	input  logic [siem_pkg::CFG_W-1:0]       frame_height,
	input  logic                             restart,
	siem_pixel_if.sink                       pixel,
	input  logic [siem_pkg::LVL_W-1:0]       level,
	output logic                             push,
	output siem_pkg::siem_job_t              push_job
);
	import siem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = 2 * PIX_W;

	logic [CW-1:0]    col_q;
	logic [CFG_W-1:0] row_q;
	logic [CW-1:0]    last_col;
	logic [CFG_W-1:0] last_row;
	logic             accept;

	logic             valid_s1;
	logic [PIX_W-1:0] px_s1;
	logic [CW-1:0]    col_s1;
	logic             interior_s1;
	logic             last_s1;
	logic [LW-1:0]    rd_s1;

	// Line memory word: upper byte two rows up, lower byte one row up
	logic [LW-1:0]    line_mem [MAX_WIDTH];

	logic [PIX_W-1:0] win_q  [3][3];
	logic [PIX_W-1:0] win_nx [3][3];

	logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
	logic [GRAD_W:0]   gx, gy;

	// Clamp the frame size to at least 3, and the width to what the line memory holds
	always_comb begin
		if (frame_width < CFG_W'(MIN_DIM)) last_col = CW'(MIN_DIM - 1);
		else if (32'(frame_width) > 32'(MAX_WIDTH)) last_col = CW'(MAX_WIDTH - 1);
		else last_col = CW'(frame_width - 1'b1);
		if (frame_height < CFG_W'(MIN_DIM)) last_row = CFG_W'(MIN_DIM - 1);
		else last_row = frame_height - 1'b1;
	end

	// Hold off while the queue could not take every transaction in flight
	assign pixel.ready = (level + LVL_W'(valid_s1)) < LVL_W'(FIFO_DEPTH);
	assign accept      = pixel.valid && pixel.ready;

	// Raster position and first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_q == last_col) begin
					col_q <= '0;
					row_q <= (row_q == last_row) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= pixel.gray_pixel;
			col_s1      <= col_q;
			interior_s1 <= (row_q >= CFG_W'(2)) && (col_q >= CW'(2));
			last_s1     <= (row_q == last_row) && (col_q == last_col);
		end
	end

	// Line memory: read at accept, write back in the following cycle
	always_ff @(posedge clk) begin
		if (accept) rd_s1 <= line_mem[col_q];
		if (valid_s1) line_mem[col_s1] <= {rd_s1[PIX_W-1:0], px_s1};
	end

	// Shift the window left and load the new right column
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r][0] = win_q[r][1];
			win_nx[r][1] = win_q[r][2];
		end
		win_nx[0][2] = rd_s1[LW-1:PIX_W];
		win_nx[1][2] = rd_s1[PIX_W-1:0];
		win_nx[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
			end
		end else if (valid_s1) begin
			win_q <= win_nx;
		end
	end

	// Sobel gradients on the updated window
	always_comb begin
		gx_pos = GRAD_W'(win_nx[0][2]) + GRAD_W'({win_nx[1][2], 1'b0}) + GRAD_W'(win_nx[2][2]);
		gx_neg = GRAD_W'(win_nx[0][0]) + GRAD_W'({win_nx[1][0], 1'b0}) + GRAD_W'(win_nx[2][0]);
		gy_pos = GRAD_W'(win_nx[2][0]) + GRAD_W'({win_nx[2][1], 1'b0}) + GRAD_W'(win_nx[2][2]);
		gy_neg = GRAD_W'(win_nx[0][0]) + GRAD_W'({win_nx[0][1], 1'b0}) + GRAD_W'(win_nx[0][2]);
		gx     = {1'b0, gx_pos} - {1'b0, gx_neg};
		gy     = {1'b0, gy_pos} - {1'b0, gy_neg};
	end

	assign push            = valid_s1 && interior_s1;
	assign push_job.gx_abs = gx[GRAD_W] ? GRAD_W'(-gx) : gx[GRAD_W-1:0];
	assign push_job.gy_abs = gy[GRAD_W] ? GRAD_W'(-gy) : gy[GRAD_W-1:0];
	assign push_job.last   = last_s1;

endmodule

`default_nettype wire

// File: rtl/siem_back.sv
`default_nettype none
`include "sobel_inverted_edge_magnitude_core_assert.svh"

module siem_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  siem_pkg::siem_job_t              head_job,
	input  logic                             head_valid,
	output logic                             pop,
	siem_result_if.source                    result
);
	import siem_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_SUM,
		S_ROOT,
		S_FINISH,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [GRAD_W-1:0]   gx_q, gy_q;
	logic                last_q;
	logic [SQ_W-1:0]     sqx_q, sqy_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [STEP_W-1:0]   step_q;
	logic [EDGE_W-1:0]   value_q;
	logic                out_valid_q;
	logic                out_last_q;

	logic [REM_W+1:0]    trial;
	logic [REM_W+1:0]    divisor;
	logic                take;
	logic [REM_W:0]      ceil_root;

	// One root digit: bring down two energy bits, try subtracting 4*root+1
	always_comb begin
		trial     = {rem_q, energy_q[ENERGY_W-1 -: 2]};
		divisor   = (REM_W+2)'({root_q, 2'b01});
		take      = (trial >= divisor);
		ceil_root = (REM_W+1)'(root_q) + (REM_W+1)'(rem_q != '0);
	end

	assign pop = (state_q == S_IDLE) && head_valid;

	// Sequencer: square, add, root digits, invert, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						gx_q    <= head_job.gx_abs;
						gy_q    <= head_job.gy_abs;
						last_q  <= head_job.last;
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					sqx_q   <= SQ_W'(gx_q) * SQ_W'(gx_q);
					sqy_q   <= SQ_W'(gy_q) * SQ_W'(gy_q);
					state_q <= S_SUM;
				end
				S_SUM: begin
					energy_q <= ENERGY_W'(sqx_q) + ENERGY_W'(sqy_q);
					rem_q    <= '0;
					root_q   <= '0;
					step_q   <= '0;
					state_q  <= S_ROOT;
				end
				S_ROOT: begin
					energy_q <= energy_q << 2;
					if (take) begin
						rem_q  <= REM_W'(trial - divisor);
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q  <= REM_W'(trial);
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ROOT_W - 1)) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (ceil_root > (REM_W+1)'(PIX_MAX)) value_q <= '0;
					else value_q <= EDGE_W'((REM_W+1)'(PIX_MAX) - ceil_root);
					out_last_q  <= last_q;
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.edge_value    = value_q;
	assign result.last_of_frame = out_last_q;

	`SIEM_ASSERT_IMP(a_root_floor, state_q == S_FINISH, (rem_q <= {root_q, 1'b0}), "root remainder too large")

endmodule

`default_nettype wire

// File: rtl/sobel_inverted_edge_magnitude_core.sv
`default_nettype none
// Inverted Sobel edge magnitude over a gray pixel stream.
// Channels: pixel (sink, gray_pixel in raster order, frame after frame) and
// result (source, edge_value = 255 - ceil(sqrt(gx^2 + gy^2)) floored at zero,
// plus last_of_frame on the final interior result). A transaction moves on a
// clock edge with valid and ready both high. The APB port holds frame_width at
// byte address 0 and frame_height at 4; a write to either restarts the frame.
// Rows 0 and 1 and columns 0 and 1 of each frame give no result, so a frame
// yields (H-2)*(W-2) results. Sizes below 3 act as 3, a width above MAX_WIDTH
// acts as MAX_WIDTH.
// Pixels enter one per clock while pixel.ready is high; the back end works on
// one interior result at a time (square, add, 11 root digits at one per cycle,
// invert, hand-off) and takes no new job until it is handed off, so a burst of
// interior pixels is taken only as fast as the back end frees the 4-entry queue.
// Reset clears the counters, window and queue and loads 640 x 480; the line
// memory is not cleared. When the receiver stalls the result is held and the
// queue fills; pixel.ready drops once no room is left for the pixel in flight.
module sobel_inverted_edge_magnitude_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [siem_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [siem_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [siem_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	siem_pixel_if.sink                          pixel,
	siem_result_if.source                       result
);
	import siem_pkg::*;

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             cfg_write;
	logic             restart;
	siem_reg_t        reg_sel;

	logic             push;
	siem_job_t        push_job;
	logic             pop;
	siem_job_t        head_job;
	logic             head_valid;
	logic [LVL_W-1:0] level;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = siem_reg_t'(paddr[2]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (reg_sel)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads and frame restart
	always_comb begin
		case (reg_sel)
			REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	assign restart = cfg_write;

	siem_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.restart      (restart),
		.pixel        (pixel),
		.level        (level),
		.push         (push),
		.push_job     (push_job)
	);

	siem_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_job   (head_job),
		.head_valid (head_valid),
		.level      (level)
	);

	siem_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire
